/* hdl/texture_page_clut_validity_tracker_assert.svh */
// ----------------------------------------------------------------------------
// texture page / clut validity tracker assertion macros
// wraps concurrent assertions on clk_i with reset disable; ASSERT_OFF drops them
// ----------------------------------------------------------------------------
`ifndef TEXTURE_PAGE_CLUT_VALIDITY_TRACKER_ASSERT_SVH
`define TEXTURE_PAGE_CLUT_VALIDITY_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF
// plain property under clk_i, disabled while rst_ni is low
`define TPCV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tpcv assertion failed");
// implication a |-> b under clk_i
`define TPCV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpcv implication failed");
`else
`define TPCV_ASSERT(lbl, prop)
`define TPCV_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

/* hdl/tpcv_pkg.sv */
// ----------------------------------------------------------------------------
// tpcv_pkg
// request/response types and constants of the texture page / clut tracker
// ----------------------------------------------------------------------------
package tpcv_pkg;

  typedef enum logic [1:0] {
    MODE_INVAL   = 2'd0,
    MODE_PAGE    = 2'd1,
    MODE_PALETTE = 2'd2
  } mode_e;

  localparam logic [1:0] FMT_4BIT  = 2'd0;
  localparam logic [1:0] FMT_8BIT  = 2'd1;
  localparam logic [1:0] FMT_16BIT = 2'd2;
  localparam logic [1:0] FMT_NONE  = 2'd3;

  localparam int unsigned PAGE_COUNT_X = 16;
  localparam int unsigned PAGE_ROWS    = 2;
  localparam int unsigned PAGE_SETS    = 6;
  localparam int unsigned PAGE_LINES   = 256;
  localparam int unsigned PAGE_COLS    = 64;
  localparam int unsigned VM_WIDTH     = 1024;
  localparam int unsigned VM_HEIGHT    = 512;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  rect_left;
    logic [8:0]  rect_top;
    logic [10:0] rect_right;
    logic [9:0]  rect_bottom;
    logic [1:0]  pixel_format;
    logic [3:0]  page_column;
    logic        page_row;
    logic [5:0]  palette_column;
    logic [8:0]  palette_line;
  } req_t;

  typedef struct packed {
    logic reload;
    logic format_error;
  } rsp_t;

  // cached palette key and its dirty flag
  typedef struct packed {
    logic       dirty;
    logic [1:0] fmt;
    logic [5:0] column;
    logic [8:0] line;
  } pal_state_t;

  // per set (format*2+row) page clear mask and palette overlap
  typedef struct packed {
    logic [PAGE_SETS-1:0][PAGE_COUNT_X-1:0] clr;
    logic                                   pal_hit;
  } overlap_t;

endpackage

/* hdl/texture_page_clut_validity_tracker.sv */
// ----------------------------------------------------------------------------
// texture_page_clut_validity_tracker
// tracks current decoded texture pages and the cached palette of a 1024x512
// halfword video memory: rectangle writes invalidate, lookups report reloads
// ----------------------------------------------------------------------------
// channel   handshake                  payload    direction
// request   in_valid_i / in_ready_o    in_req_i   in
// response  out_valid_o / out_ready_i  out_rsp_o  out
//
// one request per cycle sustained while the response side is not stalled
// the request register feeds one pass of overlap and lookup logic into the
// response register; state is updated when a request moves into it
// reset clears all page valid bits at once and marks the palette dirty
// a stalled response holds while one more request waits in the input register
// ----------------------------------------------------------------------------
`include "texture_page_clut_validity_tracker_assert.svh"

module texture_page_clut_validity_tracker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tpcv_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tpcv_pkg::rsp_t out_rsp_o
);

  // input request register
  logic           in_vld_q, in_vld_d;
  tpcv_pkg::req_t req_q;

  // response register
  logic           out_vld_q, out_vld_d;
  tpcv_pkg::rsp_t rsp_q;

  // request moves from the input register into the response register
  logic advance;

  tpcv_pkg::overlap_t   ovl;
  tpcv_pkg::pal_state_t pal;
  tpcv_pkg::rsp_t       rsp_next;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_comb begin
    in_vld_d  = in_ready_o ? in_valid_i : in_vld_q;
    out_vld_d = advance ? 1'b1 : (out_vld_q && !out_ready_i);
  end

  // overlap of the held rectangle with every page and the palette
  tpcv_overlap u_overlap (
    .req_i (req_q),
    .pal_i (pal),
    .ovl_o (ovl)
  );

  // tracking state; written only on advance so results stay in order
  tpcv_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (req_q),
    .ovl_i  (ovl),
    .pal_o  (pal),
    .rsp_o  (rsp_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      rsp_q <= rsp_next;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

  // back-pressure only when both registers are full and the sink stalls
  `TPCV_ASSERT_IMP(a_ready_low_full, !in_ready_o, in_vld_q && out_vld_q && !out_ready_i)
  // a new response only ever comes from a held request
  `TPCV_ASSERT_IMP(a_rsp_from_req, $rose(out_vld_q), $past(in_vld_q))
  // a format error never comes with a reload
  `TPCV_ASSERT(a_err_no_reload, !(out_vld_q && rsp_q.reload && rsp_q.format_error))
  // a palette lookup always leaves the palette clean
  `TPCV_ASSERT_IMP(a_pal_clean, $past(advance && req_q.mode == tpcv_pkg::MODE_PALETTE), !pal.dirty)

endmodule

/* hdl/tpcv_overlap.sv */
// ----------------------------------------------------------------------------
// tpcv_overlap
// rectangle overlap tests against all page spans and the palette span
// ----------------------------------------------------------------------------
module tpcv_overlap (
  input  tpcv_pkg::req_t       req_i,
  input  tpcv_pkg::pal_state_t pal_i,
  output tpcv_pkg::overlap_t   ovl_o
);

  logic [11:0] xe;
  logic [9:0]  ye;
  logic [11:0] left_x;
  logic [1:0]  row_hit;
  logic [15:0] hit16, hit8, hit4;
  logic [11:0] col_x;
  logic [9:0]  pal_l;
  logic [10:0] pal_r;

  // clip edges to the video memory for the page test
  always_comb begin
    xe = (req_i.rect_right > 11'(tpcv_pkg::VM_WIDTH)) ? 12'(tpcv_pkg::VM_WIDTH)
                                                      : {1'b0, req_i.rect_right};
    ye = (req_i.rect_bottom > 10'(tpcv_pkg::VM_HEIGHT)) ? 10'(tpcv_pkg::VM_HEIGHT)
                                                        : req_i.rect_bottom;
    left_x = {2'b00, req_i.rect_left};
  end

  always_comb begin
    for (int r = 0; r < tpcv_pkg::PAGE_ROWS; r++) begin
      row_hit[r] = (10'(r * tpcv_pkg::PAGE_LINES) < ye) &&
                   ({1'b0, req_i.rect_top} < 10'((r + 1) * tpcv_pkg::PAGE_LINES));
    end
  end

  always_comb begin
    col_x = '0;
    for (int c = 0; c < tpcv_pkg::PAGE_COUNT_X; c++) begin
      col_x    = 12'(c * tpcv_pkg::PAGE_COLS);
      hit16[c] = (col_x < xe) && (left_x < col_x + 12'd256);
      hit8[c]  = hit16[c] && (left_x < col_x + 12'd128);
      hit4[c]  = hit8[c] && (left_x < col_x + 12'd64);
    end
  end

  always_comb begin
    for (int r = 0; r < tpcv_pkg::PAGE_ROWS; r++) begin
      ovl_o.clr[r]     = row_hit[r] ? hit4  : '0;
      ovl_o.clr[2 + r] = row_hit[r] ? hit8  : '0;
      ovl_o.clr[4 + r] = row_hit[r] ? hit16 : '0;
    end
  end

  // palette span: 16 halfwords for four-bit, 256 otherwise; edges unclipped
  always_comb begin
    pal_l = {pal_i.column, 4'b0000};
    pal_r = {1'b0, pal_l} + ((pal_i.fmt == tpcv_pkg::FMT_4BIT) ? 11'd16 : 11'd256);
    ovl_o.pal_hit = !pal_i.dirty &&
                    (req_i.rect_top <= pal_i.line) &&
                    ({1'b0, pal_i.line} < req_i.rect_bottom) &&
                    ({1'b0, req_i.rect_left} < pal_r) &&
                    (req_i.rect_right > {1'b0, pal_l});
  end

endmodule

/* hdl/tpcv_state.sv */
// ----------------------------------------------------------------------------
// tpcv_state
// page valid bits, palette key and the response of one request
// ----------------------------------------------------------------------------
module tpcv_state (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  tpcv_pkg::req_t       req_i,
  input  tpcv_pkg::overlap_t   ovl_i,
  output tpcv_pkg::pal_state_t pal_o,
  output tpcv_pkg::rsp_t       rsp_o
);

  logic [tpcv_pkg::PAGE_SETS-1:0][tpcv_pkg::PAGE_COUNT_X-1:0] valid_q, valid_d;
  tpcv_pkg::pal_state_t pal_q, pal_d;
  logic [2:0]  idx;
  logic [15:0] cur_word;
  logic        fmt_ok;
  logic        pal_miss;

  always_comb begin
    fmt_ok   = (req_i.pixel_format != tpcv_pkg::FMT_NONE);
    idx      = {req_i.pixel_format, req_i.page_row};
    cur_word = fmt_ok ? valid_q[idx] : '0;
    pal_miss = pal_q.dirty || (pal_q.fmt != req_i.pixel_format) ||
               (pal_q.column != req_i.palette_column) ||
               (pal_q.line != req_i.palette_line);
  end

  always_comb begin
    valid_d = valid_q;
    pal_d   = pal_q;
    rsp_o   = '0;
    unique case (req_i.mode)
      tpcv_pkg::MODE_INVAL: begin
        for (int s = 0; s < tpcv_pkg::PAGE_SETS; s++) begin
          valid_d[s] = valid_q[s] & ~ovl_i.clr[s];
        end
        if (ovl_i.pal_hit) begin
          pal_d.dirty = 1'b1;
        end
      end
      tpcv_pkg::MODE_PAGE: begin
        if (!fmt_ok) begin
          rsp_o.format_error = 1'b1;
        end else if (!cur_word[req_i.page_column]) begin
          rsp_o.reload = 1'b1;
          valid_d[idx][req_i.page_column] = 1'b1;
        end
      end
      tpcv_pkg::MODE_PALETTE: begin
        if (pal_miss) begin
          rsp_o.reload = 1'b1;
          pal_d.dirty  = 1'b0;
          pal_d.fmt    = req_i.pixel_format;
          pal_d.column = req_i.palette_column;
          pal_d.line   = req_i.palette_line;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pal_q   <= '{dirty: 1'b1, fmt: 2'd0, column: 6'd0, line: 9'd0};
    end else if (en_i) begin
      valid_q <= valid_d;
      pal_q   <= pal_d;
    end
  end

  assign pal_o = pal_q;

endmodule

/* dv/tpcv_outcome_checker.sv */
// ----------------------------------------------------------------------------
// tpcv_outcome_checker
// watches both channels of the texture page / clut tracker, keeps its own copy
// of the page valid bits and the cached palette key, and compares each
// response with the outcome predicted for the oldest outstanding request
// ----------------------------------------------------------------------------
module tpcv_outcome_checker
  import tpcv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  req_t in_req_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  rsp_t out_rsp_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PAGE_COUNT_X-1:0] page_valid [PAGE_SETS];
  pal_state_t              palette;
  rsp_t                    pending_outcomes [$];
  int                      mismatches;
  int                      checked;

  // outcome of one request; updates the tracked state as the block does
  function automatic rsp_t lookup_outcome(req_t r);
    rsp_t        o;
    int unsigned left, top, right, bottom, xe, ye, x, y, pl, pr, set_idx;
    o      = '0;
    left   = r.rect_left;
    top    = r.rect_top;
    right  = r.rect_right;
    bottom = r.rect_bottom;
    case (r.mode)
      MODE_INVAL: begin
        xe = (right < VM_WIDTH) ? right : VM_WIDTH;
        ye = (bottom < VM_HEIGHT) ? bottom : VM_HEIGHT;
        // palette test works on the unclipped edges
        if (!palette.dirty && top <= palette.line && palette.line < bottom) begin
          pl = palette.column * 16;
          pr = pl + ((palette.fmt == FMT_4BIT) ? 16 : 256);
          if (left < pr && right > pl) palette.dirty = 1'b1;
        end
        for (int row = 0; row < PAGE_ROWS; row++) begin
          y = row * PAGE_LINES;
          if (y >= ye || top >= y + PAGE_LINES) continue;
          for (int col = 0; col < PAGE_COUNT_X; col++) begin
            x = col * PAGE_COLS;
            if (x >= xe || left >= x + 4 * PAGE_COLS) continue;
            page_valid[FMT_16BIT * 2 + row][col] = 1'b0;
            if (left >= x + 2 * PAGE_COLS) continue;
            page_valid[FMT_8BIT * 2 + row][col] = 1'b0;
            if (left >= x + PAGE_COLS) continue;
            page_valid[FMT_4BIT * 2 + row][col] = 1'b0;
          end
        end
      end
      MODE_PAGE: begin
        if (r.pixel_format == FMT_NONE) begin
          o.format_error = 1'b1;
        end else begin
          set_idx = int'(r.pixel_format) * 2 + int'(r.page_row);
          if (!page_valid[set_idx][r.page_column]) begin
            o.reload                         = 1'b1;
            page_valid[set_idx][r.page_column] = 1'b1;
          end
        end
      end
      MODE_PALETTE: begin
        if (palette.dirty || palette.fmt != r.pixel_format ||
            palette.column != r.palette_column || palette.line != r.palette_line) begin
          o.reload       = 1'b1;
          palette.dirty  = 1'b0;
          palette.fmt    = r.pixel_format;
          palette.column = r.palette_column;
          palette.line   = r.palette_line;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < PAGE_SETS; i++) page_valid[i] = '0;
      palette       = '0;
      palette.dirty = 1'b1;
      pending_outcomes.delete();
      mismatches    = 0;
      checked       = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (pending_outcomes.size() == 0) begin
          note_mismatch($sformatf("response with nothing outstanding, reload %0b format_error %0b",
                                  out_rsp_i.reload, out_rsp_i.format_error));
        end else begin
          want = pending_outcomes.pop_front();
          if (want.reload !== out_rsp_i.reload ||
              want.format_error !== out_rsp_i.format_error)
            note_mismatch($sformatf("reload exp %0b got %0b, format_error exp %0b got %0b",
                                    want.reload, out_rsp_i.reload,
                                    want.format_error, out_rsp_i.format_error));
        end
      end
      if (in_valid_i && in_ready_i) pending_outcomes.push_back(lookup_outcome(in_req_i));
      fail_count_o <= mismatches;
      pending_o    <= pending_outcomes.size();
      checked_o    <= checked;
    end
  end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the texture page / clut validity tracker: a short
// directed sequence over the corner cases, then random rectangle writes and
// page / palette lookups, mostly with random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tpcv_pkg::*;

  // mode 3 is not in the package enum; the block ignores it
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int LIMIT_CYCLES = 200_000;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_req;
  logic out_valid;
  logic out_ready;
  rsp_t out_rsp;

  int fail_count;
  int pending;
  int checked;
  int cycle_count;

  // set for the last part of the run: no idling on either side
  bit steady;

  // last palette key looked up, used to aim rectangles and repeat lookups
  pal_state_t pal_key;

  int n_inval, n_page, n_palette, n_ignored;

  texture_page_clut_validity_tracker u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  tpcv_outcome_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_rsp_i    (out_rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycle counter with a generous limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d responses still outstanding", cycle_count, pending);
    $display("Some tests failed");
    $finish;
  end

  // response side: ready stretches broken by random stall bursts
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      out_ready <= 1'b1;
      if (steady) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
        if ($urandom_range(0, 2) == 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
      end
    end
  end

  function automatic req_t make_req(logic [1:0] mode, int unsigned left, int unsigned top,
                                    int unsigned right, int unsigned bottom,
                                    logic [1:0] fmt, int unsigned pcol, int unsigned prow,
                                    int unsigned ccol, int unsigned cline);
    req_t r;
    r.mode           = mode;
    r.rect_left      = 10'(left);
    r.rect_top       = 9'(top);
    r.rect_right     = 11'(right);
    r.rect_bottom    = 10'(bottom);
    r.pixel_format   = fmt;
    r.page_column    = 4'(pcol);
    r.page_row       = 1'(prow);
    r.palette_column = 6'(ccol);
    r.palette_line   = 9'(cline);
    return r;
  endfunction

  // random request; fields the mode does not use stay as random noise
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick, shape, base, left, top;
    r    = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      r.mode = MODE_IGNORED;
    end else if (pick < 35) begin
      r.mode = MODE_INVAL;
      shape  = $urandom_range(0, 9);
      if (shape == 0) begin
        // anything the field widths allow: oversized, empty or inverted
        r.rect_right  = 11'($urandom_range(0, 2047));
        r.rect_bottom = 10'($urandom_range(0, 1023));
      end else if (shape == 1) begin
        // keep fully random edges
      end else if (shape < 5) begin
        // aimed at the cached palette row, hitting or just missing its span
        base = pal_key.column * 16;
        left = ((base >= 20) ? base - 20 : 0) + $urandom_range(0, 290);
        if (left > 1023) left = 1023;
        top = pal_key.line - $urandom_range(0, (pal_key.line < 8) ? pal_key.line : 8);
        r.rect_left   = 10'(left);
        r.rect_right  = 11'(left + $urandom_range(1, 32));
        r.rect_top    = 9'(top);
        r.rect_bottom = 10'(pal_key.line + $urandom_range(0, 8));
      end else begin
        // small rectangle somewhere in memory
        left = $urandom_range(0, 1023);
        top  = $urandom_range(0, 511);
        r.rect_left   = 10'(left);
        r.rect_top    = 9'(top);
        r.rect_right  = 11'(left + $urandom_range(1, 64));
        r.rect_bottom = 10'(top + $urandom_range(1, 64));
      end
    end else if (pick < 72) begin
      r.mode = MODE_PAGE;
      r.pixel_format = ($urandom_range(0, 19) == 0) ? FMT_NONE : 2'($urandom_range(0, 2));
      // a small working set of columns so that hits are common
      if ($urandom_range(0, 1) == 0) r.page_column = 4'($urandom_range(0, 3));
    end else begin
      r.mode = MODE_PALETTE;
      if ($urandom_range(0, 9) < 7) begin
        r.pixel_format   = pal_key.fmt;
        r.palette_column = pal_key.column;
        r.palette_line   = pal_key.line;
      end
      pal_key.fmt    = r.pixel_format;
      pal_key.column = r.palette_column;
      pal_key.line   = r.palette_line;
    end
    return r;
  endfunction

  // hold valid until the request is taken, then maybe idle for a burst
  task automatic send_request(input req_t r);
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    case (r.mode)
      MODE_INVAL:   n_inval++;
      MODE_PAGE:    n_page++;
      MODE_PALETTE: n_palette++;
      default:      n_ignored++;
    endcase
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // stop sending until every outstanding response has come back
  task automatic drain_responses();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    steady    = 1'b0;
    pal_key   = '0;
    n_inval   = 0;
    n_page    = 0;
    n_palette = 0;
    n_ignored = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // palette is dirty after reset, then the same key hits
    send_request(make_req(MODE_PALETTE, 0, 0, 0, 0, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PALETTE, 0, 0, 0, 0, FMT_4BIT, 0, 0, 0, 0));
    // page miss then hit, other formats of the same page miss
    send_request(make_req(MODE_PAGE, 0, 0, 0, 0, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PAGE, 0, 0, 0, 0, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PAGE, 0, 0, 0, 0, FMT_8BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PAGE, 0, 0, 0, 0, FMT_16BIT, 0, 0, 0, 0));
    // unsupported format on a page lookup
    send_request(make_req(MODE_PAGE, 0, 0, 0, 0, FMT_NONE, 5, 1, 0, 0));
    // write past the 4-bit span of page 0: wider formats lose it, 4-bit keeps it
    send_request(make_req(MODE_INVAL, 100, 0, 101, 1, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PAGE, 0, 0, 0, 0, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PAGE, 0, 0, 0, 0, FMT_8BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PALETTE, 0, 0, 0, 0, FMT_4BIT, 0, 0, 0, 0));
    // last halfword of the palette span makes it dirty, a second write keeps it so
    send_request(make_req(MODE_INVAL, 15, 0, 16, 1, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_INVAL, 15, 0, 16, 1, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PALETTE, 0, 0, 0, 0, FMT_4BIT, 0, 0, 0, 0));
    // oversized edges are clipped for the page test
    send_request(make_req(MODE_PAGE, 0, 0, 0, 0, FMT_16BIT, 15, 1, 0, 0));
    send_request(make_req(MODE_INVAL, 1023, 511, 2047, 1023, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PAGE, 0, 0, 0, 0, FMT_16BIT, 15, 1, 0, 0));
    // an inverted rectangle touches nothing; an empty one still clears pages whose span holds its left edge
    send_request(make_req(MODE_INVAL, 300, 0, 300, 512, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_INVAL, 600, 400, 10, 100, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PAGE, 0, 0, 0, 0, FMT_16BIT, 15, 1, 0, 0));
    // ignored mode with all other fields at their maximum
    send_request(make_req(MODE_IGNORED, 1023, 511, 2047, 1023, FMT_NONE, 15, 1, 63, 511));
    // format 3 palette at the far corner gets the wide span
    send_request(make_req(MODE_PALETTE, 0, 0, 0, 0, FMT_NONE, 0, 0, 63, 511));
    send_request(make_req(MODE_INVAL, 1023, 511, 1024, 512, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PALETTE, 0, 0, 0, 0, FMT_NONE, 0, 0, 63, 511));
    // key change on the format and the line, then a write over all of memory
    send_request(make_req(MODE_PALETTE, 0, 0, 0, 0, FMT_4BIT, 0, 0, 63, 510));
    send_request(make_req(MODE_INVAL, 0, 0, 1024, 512, FMT_4BIT, 0, 0, 0, 0));
    send_request(make_req(MODE_PAGE, 0, 0, 0, 0, FMT_4BIT, 0, 0, 0, 0));
    pal_key.fmt    = FMT_4BIT;
    pal_key.column = 6'd63;
    pal_key.line   = 9'd510;

    // random traffic with idling, then a full drain as back-pressure on the sender
    for (int i = 0; i < 300; i++) send_request(random_request());
    drain_responses();
    for (int i = 0; i < 220; i++) begin
      send_request(random_request());
      if ($urandom_range(0, 99) == 0) drain_responses();
    end

    // last stretch at full rate on both channels
    steady = 1'b1;
    for (int i = 0; i < 100; i++) send_request(random_request());
    drain_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("covered %0d rectangle writes, %0d page lookups, %0d palette lookups, %0d ignored",
             n_inval, n_page, n_palette, n_ignored);
    $display("%0d responses compared, %0d mismatches, %0d still outstanding",
             checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/tpcv_pkg.sv
hdl/tpcv_overlap.sv
hdl/tpcv_state.sv
hdl/texture_page_clut_validity_tracker.sv
dv/tpcv_outcome_checker.sv
dv/tb_top.sv
